@@ rtl/assert_macros.svh @@
// Assertion macros shared by the elevator car controller RTL.
// Both macros assume a signal named clk, and ASSERT_RST also rst_n, in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ rtl/ecdc_pkg.sv @@
// Package for the elevator car controller: widths, codes, reset values,
// structs and small helper functions. No dependencies.
package ecdc_pkg;

    localparam int FLOOR_COUNT_DEF = 16;
    localparam int FLOOR_W         = 4;
    localparam int TMR_W           = 16;
    localparam int LOAD_W          = 10;
    localparam int CNT_W           = 4;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;

    // Timer slots, in the order their expiries are handled on a tick
    localparam int TMR_MOVE  = 0;
    localparam int TMR_OPEN  = 1;
    localparam int TMR_DWELL = 2;
    localparam int TMR_CLOSE = 3;
    localparam int TMR_WIN   = 4;
    localparam int TMR_NUM   = 5;

    localparam logic [CNT_W-1:0] OBST_ALERT_MIN = 4'd3;
    localparam logic [CNT_W-1:0] OBST_MAX       = 4'd15;

    // Register reset values
    localparam logic [TMR_W-1:0]  FLOOR_TICKS_RST  = 16'd3000;
    localparam logic [TMR_W-1:0]  OPEN_TICKS_RST   = 16'd3000;
    localparam logic [TMR_W-1:0]  DWELL_TICKS_RST  = 16'd10000;
    localparam logic [TMR_W-1:0]  CLOSE_TICKS_RST  = 16'd5000;
    localparam logic [TMR_W-1:0]  WINDOW_TICKS_RST = 16'd40000;
    localparam logic [LOAD_W-1:0] PASS_WEIGHT_RST  = 10'd75;
    localparam logic [LOAD_W-1:0] OVER_LIMIT_RST   = 10'd300;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLOOR_TICKS  = 3'd0,
        CFG_OPEN_TICKS   = 3'd1,
        CFG_DWELL_TICKS  = 3'd2,
        CFG_CLOSE_TICKS  = 3'd3,
        CFG_WINDOW_TICKS = 3'd4,
        CFG_PASS_WEIGHT  = 3'd5,
        CFG_OVER_LIMIT   = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        FUNC_FLOOR_CMD = 3'd0,
        FUNC_TICK      = 3'd1,
        FUNC_OBSTACLE  = 3'd2,
        FUNC_CLOSE_BTN = 3'd3,
        FUNC_EMERGENCY = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_REQ    = 3'd1,
        MODE_PICKUP = 3'd2,
        MODE_OVER   = 3'd3,
        MODE_FIRE   = 3'd4,
        MODE_OUTAGE = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        DOOR_CLOSED  = 2'd0,
        DOOR_OPENING = 2'd1,
        DOOR_OPEN    = 2'd2,
        DOOR_CLOSING = 2'd3
    } door_t;

    typedef struct packed {
        logic [TMR_W-1:0]  floor_ticks;
        logic [TMR_W-1:0]  open_ticks;
        logic [TMR_W-1:0]  dwell_ticks;
        logic [TMR_W-1:0]  close_ticks;
        logic [TMR_W-1:0]  window_ticks;
        logic [LOAD_W-1:0] passenger_weight;
        logic [LOAD_W-1:0] overload_limit;
    } cfg_t;

    typedef struct packed {
        logic [FLOOR_W-1:0]              floor_now;
        logic [FLOOR_W-1:0]              floor_goal;
        mode_t                           car_mode;
        logic                            doors_are_open;
        logic                            obstacle_seen;
        logic [CNT_W-1:0]                obstacle_count;
        logic [LOAD_W-1:0]               car_load;
        logic [TMR_NUM-1:0][TMR_W-1:0]   tmr;
    } state_t;

    typedef struct packed {
        logic [FLOOR_W-1:0] current_floor;
        logic [FLOOR_W-1:0] target_floor;
        logic [2:0]         mode;
        logic [1:0]         door_status;
        logic               floor_passed;
        logic               reached_target;
        logic               door_opened;
        logic               door_closed;
        logic               obstacle_alert;
        logic               became_idle;
        logic [LOAD_W-1:0]  load;
    } res_t;

    // A zero period starts a timer as if it were one tick
    function automatic logic [TMR_W-1:0] tmr_period(input logic [TMR_W-1:0] p);
        return (p == '0) ? TMR_W'(1) : p;
    endfunction

    function automatic logic is_emergency(input mode_t m);
        return (m == MODE_FIRE) || (m == MODE_OUTAGE);
    endfunction

endpackage

@@ rtl/ecdc_if.sv @@
// Channel interfaces of the elevator car controller: event words in,
// status words out. Depends on ecdc_pkg.
interface ecdc_evt_if
    import ecdc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic [FLOOR_W-1:0] request_floor;
    logic               pickup;
    logic               emergency_kind;

    modport source (output valid, func, request_floor, pickup, emergency_kind,
                    input ready);
    modport sink   (input valid, func, request_floor, pickup, emergency_kind,
                    output ready);
endinterface

interface ecdc_res_if
    import ecdc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FLOOR_W-1:0] current_floor;
    logic [FLOOR_W-1:0] target_floor;
    logic [2:0]         mode;
    logic [1:0]         door_status;
    logic               floor_passed;
    logic               reached_target;
    logic               door_opened;
    logic               door_closed;
    logic               obstacle_alert;
    logic               became_idle;
    logic [LOAD_W-1:0]  load;

    modport source (output valid, current_floor, target_floor, mode, door_status,
                    floor_passed, reached_target, door_opened, door_closed,
                    obstacle_alert, became_idle, load,
                    input ready);
    modport sink   (input valid, current_floor, target_floor, mode, door_status,
                    floor_passed, reached_target, door_opened, door_closed,
                    obstacle_alert, became_idle, load,
                    output ready);
endinterface

@@ rtl/ecdc_cfg.sv @@
// Configuration register bank of the elevator car controller.
// Depends on ecdc_pkg.
module ecdc_cfg
    import ecdc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index; unknown indexes write nothing
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_FLOOR_TICKS:  cfg_next.floor_ticks      = cfg_data[TMR_W-1:0];
                CFG_OPEN_TICKS:   cfg_next.open_ticks       = cfg_data[TMR_W-1:0];
                CFG_DWELL_TICKS:  cfg_next.dwell_ticks      = cfg_data[TMR_W-1:0];
                CFG_CLOSE_TICKS:  cfg_next.close_ticks      = cfg_data[TMR_W-1:0];
                CFG_WINDOW_TICKS: cfg_next.window_ticks     = cfg_data[TMR_W-1:0];
                CFG_PASS_WEIGHT:  cfg_next.passenger_weight = cfg_data[LOAD_W-1:0];
                CFG_OVER_LIMIT:   cfg_next.overload_limit   = cfg_data[LOAD_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers, load defaults at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.floor_ticks      <= FLOOR_TICKS_RST;
            cfg_reg.open_ticks       <= OPEN_TICKS_RST;
            cfg_reg.dwell_ticks      <= DWELL_TICKS_RST;
            cfg_reg.close_ticks      <= CLOSE_TICKS_RST;
            cfg_reg.window_ticks     <= WINDOW_TICKS_RST;
            cfg_reg.passenger_weight <= PASS_WEIGHT_RST;
            cfg_reg.overload_limit   <= OVER_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/ecdc_core.sv @@
// Car and door state of the elevator controller with its one-pass update
// for each event word. Depends on ecdc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ecdc_core
    import ecdc_pkg::*;
#(
    parameter int FLOOR_COUNT = FLOOR_COUNT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [2:0]         func,
    input  logic [FLOOR_W-1:0] request_floor,
    input  logic               pickup,
    input  logic               emergency_kind,
    input  cfg_t               cfg,
    output res_t               res
);

    // Highest reachable floor; requests above it saturate
    localparam logic [FLOOR_W-1:0] TOP_FLOOR =
        (FLOOR_COUNT > (1 << FLOOR_W)) ? {FLOOR_W{1'b1}} : FLOOR_W'(FLOOR_COUNT - 1);

    state_t             state_reg;
    state_t             state_next;
    logic [TMR_NUM-1:0] fired;
    logic               f_passed;
    logic               f_reached;
    logic               f_opened;
    logic               f_closed;
    logic               f_alert;
    logic               f_idle;
    logic [1:0]         door_status;

    // Apply one event word; handlers run in the fixed expiry order
    always_comb
    begin
        state_next = state_reg;
        fired      = '0;
        f_passed   = 1'b0;
        f_reached  = 1'b0;
        f_opened   = 1'b0;
        f_closed   = 1'b0;
        f_alert    = 1'b0;
        f_idle     = 1'b0;

        case (func)
            FUNC_FLOOR_CMD:
            begin
                if (is_emergency(state_next.car_mode))
                begin
                    if (!(state_next.doors_are_open && !state_next.obstacle_seen))
                        state_next.tmr[TMR_OPEN] = tmr_period(cfg.open_ticks);
                end
                else
                begin
                    state_next.floor_goal = (request_floor > TOP_FLOOR) ? TOP_FLOOR
                                                                        : request_floor;
                    state_next.car_mode   = pickup ? MODE_PICKUP : MODE_REQ;
                    if (!state_next.doors_are_open &&
                        (state_next.floor_now != state_next.floor_goal))
                        state_next.tmr[TMR_MOVE] = tmr_period(cfg.floor_ticks);
                end
            end

            FUNC_TICK:
            begin
                // Count every running timer down and flag the ones that run out
                for (int t = 0; t < TMR_NUM; t++)
                begin
                    if (state_next.tmr[t] != '0)
                    begin
                        state_next.tmr[t] = state_next.tmr[t] - TMR_W'(1);
                        fired[t]          = (state_next.tmr[t] == '0);
                    end
                end

                // Floor move period ended
                if (fired[TMR_MOVE])
                begin
                    if (is_emergency(state_next.car_mode))
                    begin
                        state_next.tmr[TMR_MOVE] = '0;
                    end
                    else
                    begin
                        if (state_next.floor_now < state_next.floor_goal)
                        begin
                            state_next.floor_now = state_next.floor_now + FLOOR_W'(1);
                            f_passed             = 1'b1;
                        end
                        else if (state_next.floor_now > state_next.floor_goal)
                        begin
                            state_next.floor_now = state_next.floor_now - FLOOR_W'(1);
                            f_passed             = 1'b1;
                        end
                        if (state_next.floor_now == state_next.floor_goal)
                        begin
                            f_reached                = 1'b1;
                            state_next.tmr[TMR_MOVE] = '0;
                            if (!(state_next.doors_are_open && !state_next.obstacle_seen))
                            begin
                                state_next.tmr[TMR_OPEN] = tmr_period(cfg.open_ticks);
                                fired[TMR_OPEN]          = 1'b0;
                            end
                        end
                        else
                        begin
                            state_next.tmr[TMR_MOVE] = tmr_period(cfg.floor_ticks);
                        end
                    end
                end

                // Doors finished opening: board or unboard, then start dwell unless newly overloaded or in emergency
                if (fired[TMR_OPEN])
                begin
                    state_next.tmr[TMR_OPEN]  = '0;
                    state_next.doors_are_open = 1'b1;
                    f_opened                  = 1'b1;
                    if (state_next.car_mode == MODE_PICKUP)
                    begin
                        if (state_next.car_load == '0)
                        begin
                            state_next.car_load = cfg.passenger_weight;
                            if (state_next.car_load >= cfg.overload_limit)
                                state_next.car_mode = MODE_OVER;
                        end
                    end
                    else if (state_next.car_mode == MODE_REQ)
                    begin
                        state_next.car_load =
                            (state_next.car_load >= cfg.passenger_weight)
                                ? state_next.car_load - cfg.passenger_weight : '0;
                        if (state_next.car_load < cfg.overload_limit)
                            state_next.car_mode = MODE_IDLE;
                    end
                    if (!(f_opened && state_next.car_mode == MODE_OVER &&
                          state_reg.car_mode == MODE_PICKUP) &&
                        !is_emergency(state_next.car_mode))
                    begin
                        state_next.tmr[TMR_DWELL] = tmr_period(cfg.dwell_ticks);
                        fired[TMR_DWELL]          = 1'b0;
                    end
                end

                // Dwell ran out: start closing
                if (fired[TMR_DWELL])
                begin
                    if (state_next.doors_are_open)
                    begin
                        state_next.tmr[TMR_DWELL] = '0;
                        state_next.obstacle_seen  = 1'b0;
                        state_next.tmr[TMR_CLOSE] = tmr_period(cfg.close_ticks);
                        fired[TMR_CLOSE]          = 1'b0;
                    end
                end

                // Doors finished closing, or reopen after an obstacle
                if (fired[TMR_CLOSE])
                begin
                    state_next.tmr[TMR_CLOSE] = '0;
                    if (state_next.obstacle_seen)
                    begin
                        if (!state_next.doors_are_open)
                            state_next.tmr[TMR_OPEN] = tmr_period(cfg.open_ticks);
                    end
                    else
                    begin
                        state_next.tmr[TMR_WIN]   = '0;
                        fired[TMR_WIN]            = 1'b0;
                        f_closed                  = 1'b1;
                        state_next.doors_are_open = 1'b0;
                        if ((state_next.car_mode == MODE_PICKUP) &&
                            (state_next.floor_now != state_next.floor_goal))
                            state_next.tmr[TMR_MOVE] = tmr_period(cfg.floor_ticks);
                        if ((state_next.car_mode == MODE_REQ) ||
                            is_emergency(state_next.car_mode))
                        begin
                            state_next.car_mode = MODE_IDLE;
                            f_idle              = 1'b1;
                        end
                    end
                end

                // Obstacle window ended
                if (fired[TMR_WIN])
                begin
                    state_next.tmr[TMR_WIN]   = '0;
                    f_alert                   = (state_next.obstacle_count >= OBST_ALERT_MIN);
                    state_next.obstacle_count = '0;
                end
            end

            FUNC_OBSTACLE:
            begin
                if (state_next.obstacle_count == '0)
                begin
                    state_next.obstacle_count = CNT_W'(1);
                    state_next.tmr[TMR_WIN]   = tmr_period(cfg.window_ticks);
                end
                else if (state_next.obstacle_count < OBST_MAX)
                begin
                    state_next.obstacle_count = state_next.obstacle_count + CNT_W'(1);
                end
                state_next.obstacle_seen  = 1'b1;
                state_next.tmr[TMR_DWELL] = '0;
                state_next.tmr[TMR_CLOSE] = '0;
                // Obstacle seen, so the doors always reopen
                state_next.tmr[TMR_OPEN]  = tmr_period(cfg.open_ticks);
            end

            FUNC_CLOSE_BTN:
            begin
                if (state_next.doors_are_open)
                begin
                    state_next.tmr[TMR_DWELL] = '0;
                    state_next.obstacle_seen  = 1'b0;
                    state_next.tmr[TMR_CLOSE] = tmr_period(cfg.close_ticks);
                end
            end

            FUNC_EMERGENCY:
            begin
                state_next.car_mode = emergency_kind ? MODE_OUTAGE : MODE_FIRE;
            end

            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    // Report closing over opening, opening over open or closed
    always_comb
    begin
        if (state_next.tmr[TMR_CLOSE] != '0)
            door_status = DOOR_CLOSING;
        else if (state_next.tmr[TMR_OPEN] != '0)
            door_status = DOOR_OPENING;
        else if (state_next.doors_are_open)
            door_status = DOOR_OPEN;
        else
            door_status = DOOR_CLOSED;
    end

    always_comb
    begin
        res.current_floor  = state_next.floor_now;
        res.target_floor   = state_next.floor_goal;
        res.mode           = state_next.car_mode;
        res.door_status    = door_status;
        res.floor_passed   = f_passed;
        res.reached_target = f_reached;
        res.door_opened    = f_opened;
        res.door_closed    = f_closed;
        res.obstacle_alert = f_alert;
        res.became_idle    = f_idle;
        res.load           = state_next.car_load;
    end

    // Advance the state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (step)
            state_reg <= state_next;
    end

    `ASSERT_RST(a_passed_moves, step && f_passed |=> state_reg.floor_now != $past(state_reg.floor_now), "floor_passed without a floor change")
    `ASSERT_RST(a_idle_mode, step && f_idle |=> state_reg.car_mode == MODE_IDLE, "became_idle but mode is not idle")
    `ASSERT_RST(a_load_on_tick, step && (func != FUNC_TICK) |=> $stable(state_reg.car_load), "load changed outside a tick")

endmodule

@@ rtl/elevator_car_door_controller_top.sv @@
// Top level of the elevator car and door controller.
// Depends on ecdc_pkg, ecdc_if, ecdc_cfg, ecdc_core and assert_macros.svh.
//
// Usage:
//   evt carries event words (floor command, tick, obstacle, close button,
//   emergency); res returns one status word for every event word.
//   The configuration port writes one register per cycle with cfg_we high;
//   write it only while no event word is in flight.
//   Each status word is registered as its event word is accepted and shows
//   on res in the cycle after. Throughput: one event word per cycle, set by
//   the single state update between the car state registers and the result
//   register, when res does not stall. When res is stalled, the result
//   register holds its word and evt.ready drops until the word is taken; a
//   word taken while a new one is accepted is replaced in the same cycle.
//   Reset (rst_n low) loads default timing and load registers, puts the car
//   at floor 0, idle, doors closed, empty, all timers stopped, and empties
//   the result register.
`include "assert_macros.svh"

module elevator_car_door_controller_top
    import ecdc_pkg::*;
#(
    parameter int FLOOR_COUNT = FLOOR_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    ecdc_evt_if.sink              evt,
    ecdc_res_if.source            res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;
    res_t res_word;
    res_t res_reg;
    logic res_valid_reg;
    logic res_valid_next;
    logic evt_ready;
    logic evt_accept;

    ecdc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ecdc_core #(
        .FLOOR_COUNT (FLOOR_COUNT)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (evt_accept),
        .func           (evt.func),
        .request_floor  (evt.request_floor),
        .pickup         (evt.pickup),
        .emergency_kind (evt.emergency_kind),
        .cfg            (cfg),
        .res            (res_word)
    );

    // Take a new word whenever the result register is free or being drained
    assign evt_ready  = !res_valid_reg || res.ready;
    assign evt_accept = evt.valid && evt_ready;
    assign evt.ready  = evt_ready;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (evt_accept)
            res_valid_next = 1'b1;
        else if (res.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    // Load the result word on accept, hold it otherwise
    always_ff @(posedge clk)
    begin
        if (evt_accept)
            res_reg <= res_word;
    end

    assign res.valid          = res_valid_reg;
    assign res.current_floor  = res_reg.current_floor;
    assign res.target_floor   = res_reg.target_floor;
    assign res.mode           = res_reg.mode;
    assign res.door_status    = res_reg.door_status;
    assign res.floor_passed   = res_reg.floor_passed;
    assign res.reached_target = res_reg.reached_target;
    assign res.door_opened    = res_reg.door_opened;
    assign res.door_closed    = res_reg.door_closed;
    assign res.obstacle_alert = res_reg.obstacle_alert;
    assign res.became_idle    = res_reg.became_idle;
    assign res.load           = res_reg.load;

    `ASSERT_RST(a_accept_gives_result, evt.valid && evt.ready |=> res.valid, "accepted word produced no result")
    `ASSERT_RST(a_ready_when_empty, !res.valid |-> evt.ready, "input stalled with empty result register")
    `ASSERT_RST(a_drain_empties, res.valid && res.ready && !evt.valid |=> !res.valid, "result repeated after being taken")

endmodule
